[hdl/slr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg
// shared types, constants and helpers of the string table record locator
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int POS_W = 24;
    localparam int LEN_W = 15;
    localparam int IDX_W = 16;

    localparam logic [7:0] LEN_EXT_FLAG = 8'h80;
    localparam logic [7:0] LEN_LOW_MASK = 8'h7f;

    // configuration register indexes (word address bit 2)
    localparam logic REG_WANTED_INDEX    = 1'b0;
    localparam logic REG_RESOURCE_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_HEADER = 2'd1,
        ST_TRUNC  = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
    } t_res_data;

    typedef struct packed {
        logic      valid;
        t_res_data data;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_buf_status;

    // header magic 00 45 53 ff
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h00;
            2'd1:    val = 8'h45;
            2'd2:    val = 8'h53;
            default: val = 8'hff;
        endcase
        return val;
    endfunction

endpackage

[hdl/slr_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_parser
// per-byte parse state and single-pass step logic of the record walk
// ----------------------------------------------------------------------------
module slr_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first,
    input  logic [slr_pkg::IDX_W-1:0]     i_wanted_index,
    input  logic [slr_pkg::POS_W-1:0]     i_resource_length,
    output slr_pkg::t_result              o_result
);
    import slr_pkg::*;

    typedef enum logic [2:0] {
        PH_DONE  = 3'd0,
        PH_MAGIC = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LEN2  = 3'd3,
        PH_SKIP  = 3'd4
    } t_phase;

    t_phase             r_phase, n_phase, e_phase;
    logic [POS_W-1:0]   r_pos, n_pos, e_pos;
    logic [LEN_W-1:0]   r_skip, n_skip, e_skip;
    logic [IDX_W-1:0]   r_recs, n_recs, e_recs;
    logic [6:0]         r_hi, n_hi, e_hi;

    logic [POS_W:0]     pos_inc;
    logic [POS_W+1:0]   rec_end;
    logic [LEN_W-1:0]   rec_len;
    logic               take;
    logic               fin;
    t_status            fin_status;
    logic [POS_W-1:0]   fin_offset;
    logic [LEN_W-1:0]   fin_length;

    always_comb begin
        // a first byte restarts the parse before the byte itself is looked at
        e_phase = r_phase;
        e_pos   = r_pos;
        e_skip  = r_skip;
        e_recs  = r_recs;
        e_hi    = r_hi;
        if (i_first) begin
            e_phase = PH_MAGIC;
            e_pos   = '0;
            e_skip  = '0;
            e_recs  = i_wanted_index;
            e_hi    = '0;
        end

        n_phase = e_phase;
        n_pos   = e_pos;
        n_skip  = e_skip;
        n_recs  = e_recs;
        n_hi    = e_hi;

        pos_inc = {1'b0, e_pos} + {{POS_W{1'b0}}, 1'b1};
        if (e_phase == PH_LEN2) begin
            rec_len = {e_hi, i_data_byte};
        end else begin
            rec_len = {8'd0, i_data_byte[6:0] & LEN_LOW_MASK[6:0]};
        end
        rec_end = {1'b0, pos_inc} + {{(POS_W+2-LEN_W){1'b0}}, rec_len};

        take       = 1'b0;
        fin        = 1'b0;
        fin_status = ST_FOUND;
        fin_offset = '0;
        fin_length = '0;

        if (i_first && (i_resource_length < 24'd4)) begin
            fin        = 1'b1;
            fin_status = ST_HEADER;
        end else begin
            case (e_phase)
                PH_MAGIC: begin
                    if (i_data_byte != magic_byte(e_pos[1:0])) begin
                        fin        = 1'b1;
                        fin_status = ST_HEADER;
                    end else begin
                        n_pos = pos_inc[POS_W-1:0];
                        if (pos_inc[POS_W-1:0] >= 24'd4) begin
                            if (pos_inc[POS_W-1:0] >= i_resource_length) begin
                                fin        = 1'b1;
                                fin_status = ST_ABSENT;
                            end else begin
                                n_phase = PH_LEN1;
                            end
                        end
                    end
                end
                PH_LEN1: begin
                    if ((i_data_byte & LEN_EXT_FLAG) != 8'd0) begin
                        if (pos_inc >= {1'b0, i_resource_length}) begin
                            fin        = 1'b1;
                            fin_status = ST_TRUNC;
                        end else begin
                            n_hi    = i_data_byte[6:0];
                            n_pos   = pos_inc[POS_W-1:0];
                            n_phase = PH_LEN2;
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_LEN2: begin
                    take = 1'b1;
                end
                PH_SKIP: begin
                    n_pos  = pos_inc[POS_W-1:0];
                    n_skip = e_skip - 15'd1;
                    if (n_skip == '0) begin
                        if (pos_inc[POS_W-1:0] >= i_resource_length) begin
                            fin        = 1'b1;
                            fin_status = ST_ABSENT;
                        end else begin
                            n_phase = PH_LEN1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // complete length prefix: overrun check, hit, or pass the record
        if (take) begin
            if (rec_end > {2'b00, i_resource_length}) begin
                fin        = 1'b1;
                fin_status = ST_TRUNC;
            end else if (e_recs == '0) begin
                fin        = 1'b1;
                fin_status = ST_FOUND;
                fin_offset = pos_inc[POS_W-1:0];
                fin_length = rec_len;
            end else begin
                n_recs = e_recs - 16'd1;
                n_pos  = pos_inc[POS_W-1:0];
                if (rec_len == '0) begin
                    if (pos_inc[POS_W-1:0] >= i_resource_length) begin
                        fin        = 1'b1;
                        fin_status = ST_ABSENT;
                    end else begin
                        n_phase = PH_LEN1;
                    end
                end else begin
                    n_skip  = rec_len;
                    n_phase = PH_SKIP;
                end
            end
        end

        if (fin) begin
            n_phase = PH_DONE;
        end

        o_result.valid       = i_step && fin;
        o_result.data.status = fin_status;
        o_result.data.offset = fin_offset;
        o_result.data.length = fin_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_pos   <= '0;
            r_skip  <= '0;
            r_recs  <= '0;
            r_hi    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_recs  <= n_recs;
            r_hi    <= n_hi;
        end
    end

    // a found record always lies after the header and its own prefix
    a_found_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.data.status == ST_FOUND))
            |-> (o_result.data.offset >= 24'd5))
        else $error("found offset inside header");

    // a found record fits inside the resource
    a_found_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.data.status == ST_FOUND))
            |-> (({1'b0, o_result.data.offset} + {10'd0, o_result.data.length})
                 <= {1'b0, i_resource_length}))
        else $error("found record overruns resource");

    // once done, only a first byte can produce a result
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_DONE) && !i_first) |-> !o_result.valid)
        else $error("result while parse done");

endmodule

[hdl/slr_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_out_buf
// two-entry result buffer that decouples the parser from output stalls
// ----------------------------------------------------------------------------
module slr_out_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slr_pkg::t_result              i_push,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output slr_pkg::t_res_data            o_out_data,
    output slr_pkg::t_buf_status          o_status
);
    import slr_pkg::*;

    t_res_data   r_entry [2];
    logic        r_head, n_head;
    logic        r_tail, n_tail;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign pop            = (r_count != 2'd0) && !i_out_stall;
    assign o_out_valid    = (r_count != 2'd0);
    assign o_out_data     = r_entry[r_head];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_comb begin
        n_head  = r_head ^ pop;
        n_tail  = r_tail ^ i_push.valid;
        n_count = r_count + {1'b0, i_push.valid} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_tail] <= i_push.data;
        end
    end

endmodule

[hdl/string_table_record_locator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_table_record_locator
// scans a serialized string table byte by byte and locates one record
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall) carries one resource byte per
//   transfer; i_first marks byte 0 and restarts the parse. the output channel
//   (o_out_valid / i_out_stall) carries at most one result per resource:
//   status, text offset and text length of the record numbered wanted_index.
//   registers wanted_index (addr 0) and resource_length (addr 4) are written
//   over the apb port while no resource is in flight.
// timing
//   a byte is taken into the input register, stepped through the parser from
//   there, and its result lands in a two-entry output buffer, from which it
//   transfers on the output channel. throughput is one byte per cycle while
//   the output buffer has room, set by the single parser step between input
//   register and output buffer.
// stalls and reset
//   when the receiver stalls, results pile up in the output buffer; with both
//   entries full the parser holds and o_in_stall rises. reset clears the
//   handshake and leaves the parser done, ignoring bytes until a first byte.
// ----------------------------------------------------------------------------
module string_table_record_locator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_first,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [slr_pkg::POS_W-1:0]   o_string_offset,
    output logic [slr_pkg::LEN_W-1:0]   o_string_length,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import slr_pkg::*;

    // configuration registers
    logic [IDX_W-1:0]   r_wanted_index;
    logic [POS_W-1:0]   r_resource_length;
    logic               cfg_wr;

    // input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_first;
    logic               in_xfer;
    logic               advance;

    t_result            parse_res;
    t_res_data          out_data;
    t_buf_status        buf_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_index    <= '0;
            r_resource_length <= 24'd1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WANTED_INDEX:    r_wanted_index    <= pwdata[IDX_W-1:0];
                REG_RESOURCE_LENGTH: r_resource_length <= pwdata[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[2])
            REG_WANTED_INDEX:    prdata = {16'd0, r_wanted_index};
            REG_RESOURCE_LENGTH: prdata = {8'd0, r_resource_length};
            default:             prdata = '0;
        endcase
    end

    // the parser steps whenever a byte waits and the result buffer has room;
    // stall depends on registers only
    assign advance    = r_in_valid && !buf_stat.full;
    assign o_in_stall = r_in_valid && buf_stat.full;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // byte payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first;
        end
    end

    slr_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (advance),
        .i_data_byte       (r_in_byte),
        .i_first           (r_in_first),
        .i_wanted_index    (r_wanted_index),
        .i_resource_length (r_resource_length),
        .o_result          (parse_res)
    );

    slr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (parse_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (out_data),
        .o_status    (buf_stat)
    );

    assign o_status        = out_data.status;
    assign o_string_offset = out_data.offset;
    assign o_string_length = out_data.length;

    // input stalls only for a waiting byte behind a full result buffer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && buf_stat.full))
        else $error("input stall without full buffer");

    // a result from the parser is offered at the output on the next cycle
    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_res.valid |=> o_out_valid)
        else $error("parser result not offered");

    // an empty result buffer offers nothing
    a_empty_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_stat.empty |-> !o_out_valid)
        else $error("output valid from empty buffer");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the string table record locator: a queue-fed byte
// driver and a result monitor, both with random idle cycles, check every
// result against a cycle-free model of the record walk kept in the bench.
// registers are rewritten between phases once all results are in; a short
// directed run hits the named corner cases, then random phases with mostly
// well-formed tables and some broken ones follow
// ----------------------------------------------------------------------------
module tb_top;

    import slr_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int DRAIN_CYCLES = 12;       // parser plus output buffer, with margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 975;      // directed part plus about 950 random

    localparam logic [2:0]  ADDR_WANTED_INDEX    = {REG_WANTED_INDEX, 2'b00};
    localparam logic [2:0]  ADDR_RESOURCE_LENGTH = {REG_RESOURCE_LENGTH, 2'b00};
    localparam logic [31:0] TABLE_MAGIC          = 32'h004553FF;

    // phase of the bench-side record walk
    typedef enum logic [2:0] {
        SCAN_DONE,
        SCAN_MAGIC,
        SCAN_PREFIX,
        SCAN_PREFIX_LO,
        SCAN_TEXT
    } t_scan_phase;

    // how a generated table is built
    typedef enum logic [2:0] {
        SHAPE_CLEAN,
        SHAPE_BAD_MAGIC,
        SHAPE_OVERRUN,
        SHAPE_CUT_PREFIX,
        SHAPE_ABANDONED,
        SHAPE_TRAILING,
        SHAPE_NOISE
    } t_table_shape;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_byte_xfer;

    // dut ports, all driven from time zero
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_data_byte     = '0;
    logic                i_first         = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic [1:0]          o_status;
    logic [POS_W-1:0]    o_string_offset;
    logic [LEN_W-1:0]    o_string_length;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [2:0]          paddr           = '0;
    logic [31:0]         pwdata          = '0;
    logic [31:0]         prdata;
    logic                pready;

    // stimulus and result stores
    t_byte_xfer          bytes_to_send[$];
    t_res_data           lookups_due[$];
    int                  sent_total  = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;

    // register copies used by the bench-side walk
    logic [IDX_W-1:0]    cfg_wanted = '0;
    logic [POS_W-1:0]    cfg_rlen   = 24'd1;

    // bench-side walk state
    t_scan_phase         scan_phase   = SCAN_DONE;
    logic [POS_W-1:0]    scan_pos     = '0;
    logic [LEN_W-1:0]    text_left    = '0;
    logic [IDX_W-1:0]    records_left = '0;
    logic [6:0]          len_hi       = '0;

    // idle control for both channels
    bit                  send_calm = 1'b0;
    bit                  take_calm = 1'b0;
    int                  send_gap  = 0;
    int                  hold_left = 0;

    string_table_record_locator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_first         (i_first),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_string_offset (o_string_offset),
        .o_string_length (o_string_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // bench-side record walk
    // ------------------------------------------------------------------------

    function automatic logic [7:0] magic_at(input int k);
        return TABLE_MAGIC[8*(3-k) +: 8];
    endfunction

    // one result ends the walk until the next first byte
    function automatic void close_scan(input t_status st, input logic [POS_W-1:0] off,
                                       input logic [LEN_W-1:0] len);
        t_res_data r;
        r.status = st;
        r.offset = off;
        r.length = len;
        lookups_due.push_back(r);
        scan_phase = SCAN_DONE;
    endfunction

    // a complete length prefix is known; text starts at text_start
    function automatic void record_length(input logic [POS_W:0] text_start,
                                          input logic [LEN_W-1:0] len);
        logic [POS_W+1:0] text_end;
        text_end = {1'b0, text_start} + {{(POS_W+2-LEN_W){1'b0}}, len};
        if (text_end > {2'b00, cfg_rlen}) begin
            close_scan(ST_TRUNC, '0, '0);
        end else if (records_left == 0) begin
            close_scan(ST_FOUND, text_start[POS_W-1:0], len);
        end else begin
            records_left = records_left - 16'd1;
            scan_pos = text_start[POS_W-1:0];
            if (len == 0) begin
                // an empty record may itself be the end of the table
                if (scan_pos >= cfg_rlen) begin
                    close_scan(ST_ABSENT, '0, '0);
                end else begin
                    scan_phase = SCAN_PREFIX;
                end
            end else begin
                text_left = len;
                scan_phase = SCAN_TEXT;
            end
        end
    endfunction

    // advance the walk by one accepted byte, queueing any result it causes
    function automatic void locate_step(input logic [7:0] b, input logic is_first);
        logic [POS_W:0] nxt;
        if (is_first) begin
            scan_pos     = '0;
            text_left    = '0;
            len_hi       = '0;
            records_left = cfg_wanted;
            scan_phase   = SCAN_MAGIC;
        end
        nxt = {1'b0, scan_pos} + {{POS_W{1'b0}}, 1'b1};
        if (is_first && cfg_rlen < 4) begin
            close_scan(ST_HEADER, '0, '0);
        end else begin
            case (scan_phase)
                SCAN_MAGIC: begin
                    if (b != magic_at(scan_pos[1:0])) begin
                        close_scan(ST_HEADER, '0, '0);
                    end else begin
                        scan_pos = nxt[POS_W-1:0];
                        if (scan_pos >= 4) begin
                            if (scan_pos >= cfg_rlen) begin
                                close_scan(ST_ABSENT, '0, '0);
                            end else begin
                                scan_phase = SCAN_PREFIX;
                            end
                        end
                    end
                end
                SCAN_PREFIX: begin
                    if ((b & LEN_EXT_FLAG) != 0) begin
                        // wide prefix needs one more byte inside the table
                        if (nxt >= {1'b0, cfg_rlen}) begin
                            close_scan(ST_TRUNC, '0, '0);
                        end else begin
                            len_hi = b[6:0] & LEN_LOW_MASK[6:0];
                            scan_pos = nxt[POS_W-1:0];
                            scan_phase = SCAN_PREFIX_LO;
                        end
                    end else begin
                        record_length(nxt, {7'd0, b});
                    end
                end
                SCAN_PREFIX_LO: begin
                    record_length(nxt, {len_hi, b});
                end
                SCAN_TEXT: begin
                    scan_pos = nxt[POS_W-1:0];
                    text_left = text_left - 15'd1;
                    if (text_left == 0) begin
                        if (scan_pos >= cfg_rlen) begin
                            close_scan(ST_ABSENT, '0, '0);
                        end else begin
                            scan_phase = SCAN_PREFIX;
                        end
                    end
                end
                default: begin
                    // done: bytes are dropped until a first byte
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: one transfer per queued byte, random idle cycles between
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        logic       taken;
        t_byte_xfer nxt;
        taken = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (taken) begin
                locate_step(i_data_byte, i_first);
                // idle pattern switches now and then between bursts and gaps
                if ($urandom_range(0, 31) == 0) begin
                    send_calm = !send_calm;
                end
                send_gap = send_calm ? 0 : $urandom_range(0, 8);
            end
            // payload only moves once the current transfer is done
            if (!i_in_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    nxt = bytes_to_send.pop_front();
                    i_in_valid  <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_first     <= nxt.first;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares each transfer, stalls at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_res_data want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (lookups_due.size() == 0) begin
                    $error("unexpected result: status %0d offset %0d length %0d",
                           o_status, o_string_offset, o_string_length);
                    error_count = error_count + 1;
                end else begin
                    want = lookups_due.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count = error_count + 1;
                    end
                    if (o_string_offset !== want.offset) begin
                        $error("string_offset: expected %0d, got %0d",
                               want.offset, o_string_offset);
                        error_count = error_count + 1;
                    end
                    if (o_string_length !== want.length) begin
                        $error("string_length: expected %0d, got %0d",
                               want.length, o_string_length);
                        error_count = error_count + 1;
                    end
                end
                if ($urandom_range(0, 15) == 0) begin
                    take_calm = !take_calm;
                end
                hold_left = take_calm ? 0 : $urandom_range(0, 8);
            end
            // stall counts down only while a result waits, so the buffer fills
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                if (o_out_valid) begin
                    hold_left = hold_left - 1;
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic f, input bit counted);
        t_byte_xfer x;
        x.data  = b;
        x.first = f;
        bytes_to_send.push_back(x);
        if (counted) begin
            sent_total = sent_total + 1;
        end
    endtask

    task automatic send_magic();
        int k;
        for (k = 0; k < 4; k++) begin
            send_byte(magic_at(k), k == 0, 1'b1);
        end
    endtask

    // sender holds off until every queued byte is taken and all results are in
    task automatic wait_quiet();
        @(negedge i_clk);
        while (bytes_to_send.size() != 0 || i_in_valid || lookups_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [IDX_W-1:0] want, input logic [POS_W-1:0] rlen);
        wait_quiet();
        write_reg(ADDR_WANTED_INDEX, {16'd0, want});
        write_reg(ADDR_RESOURCE_LENGTH, {8'd0, rlen});
        cfg_wanted = want;
        cfg_rlen   = rlen;
    endtask

    // builds one table of total bytes and queues it; roomy caps record lengths but for the overrun shape
    task automatic queue_table(input int total, input int roomy, input t_table_shape shape);
        logic [7:0]       img[$];
        logic [LEN_W-1:0] len;
        int               rem;
        int               room;
        int               keep;
        int               k;
        bit               wide;
        if (shape == SHAPE_NOISE) begin
            for (k = 0; k < total; k++) begin
                send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
            end
            return;
        end
        for (k = 0; k < 4; k++) begin
            img.push_back(magic_at(k));
        end
        if (shape == SHAPE_BAD_MAGIC) begin
            k = $urandom_range(0, 3);
            img[k] = img[k] ^ 8'($urandom_range(1, 255));
        end
        while (img.size() < total) begin
            rem = total - img.size();
            if (rem == 1) begin
                // lone byte left: closing empty record or half of a wide prefix
                if (shape == SHAPE_CUT_PREFIX) begin
                    img.push_back(LEN_EXT_FLAG | 8'($urandom_range(0, 127)));
                end else begin
                    img.push_back(8'h00);
                end
                break;
            end
            wide = (rem >= 3) && ($urandom_range(0, 3) == 0);
            room = rem - (wide ? 2 : 1);
            if (room <= roomy && shape == SHAPE_OVERRUN) begin
                len = LEN_W'(room + 1 + int'($urandom_range(0, 2)));
            end else if (room <= roomy && shape == SHAPE_CUT_PREFIX) begin
                len = LEN_W'(room - 1);
            end else begin
                len = LEN_W'($urandom_range(0, (room < roomy) ? room : roomy));
            end
            if (len > LEN_LOW_MASK && !wide) begin
                wide = 1'b1;
                if (int'(len) > rem - 2) begin
                    len = LEN_W'(rem - 2);
                end
            end
            if (wide) begin
                img.push_back(LEN_EXT_FLAG | {1'b0, len[14:8]});
            end
            img.push_back(len[7:0]);
            for (k = 0; k < int'(len) && img.size() < total; k++) begin
                img.push_back(8'($urandom));
            end
        end
        keep = (total < img.size()) ? total : img.size();
        if (shape == SHAPE_ABANDONED && keep > 1) begin
            keep = $urandom_range(1, keep - 1);
        end
        for (k = 0; k < keep; k++) begin
            send_byte(img[k], k == 0, 1'b1);
        end
        if (shape == SHAPE_TRAILING) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [IDX_W-1:0] want;
        logic [POS_W-1:0] rlen;
        int               roomy;
        int               pick;
        t_table_shape     shape;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: index 0, length 1
        send_byte(8'hA5, 1'b0, 1'b0);      // dropped, parser is done after reset
        send_byte(8'h00, 1'b1, 1'b1);      // length below the header size

        // longest resource, widest length on the first record
        configure(16'd0, 24'hFFFFFF);
        send_magic();
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);      // magic broken on the second byte
        send_byte(8'h46, 1'b0, 1'b1);

        // highest index, table ends right after the magic
        configure(16'hFFFF, 24'd4);
        send_magic();

        // wide prefix starting on the last byte
        configure(16'd0, 24'd5);
        send_magic();
        send_byte(LEN_EXT_FLAG, 1'b0, 1'b1);

        // empty record ends the table before the index is reached
        configure(16'd5, 24'd6);
        send_magic();
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);

        // random phases: new settings, then a few tables with one shape each
        while (sent_total < ITEM_TARGET) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                // one long table with wide prefixes
                configure(16'($urandom_range(0, 2)), 24'($urandom_range(270, 400)));
                queue_table(cfg_rlen, 400, SHAPE_CLEAN);
            end else begin
                pick = $urandom_range(0, 15);
                want = (pick < 2) ? 16'hFFFF : (pick < 4) ? 16'd0 : 16'($urandom_range(1, 6));
                pick = $urandom_range(0, 15);
                rlen = (pick == 0) ? 24'($urandom_range(1, 3)) : 24'($urandom_range(4, 32));
                roomy = 12;
                configure(want, rlen);
                repeat ($urandom_range(3, 6)) begin
                    pick = $urandom_range(0, 19);
                    case (pick)
                        11:      shape = SHAPE_BAD_MAGIC;
                        12, 13:  shape = SHAPE_OVERRUN;
                        14, 15:  shape = SHAPE_CUT_PREFIX;
                        16:      shape = SHAPE_ABANDONED;
                        17:      shape = SHAPE_TRAILING;
                        18:      shape = SHAPE_NOISE;
                        default: shape = SHAPE_CLEAN;
                    endcase
                    queue_table(rlen, roomy, shape);
                end
            end
        end

        wait_quiet();
        if (error_count == 0) begin
            $display("PASS string_table_record_locator");
        end else begin
            $display("FAIL string_table_record_locator");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL string_table_record_locator");
        $finish;
    end

endmodule
